### hw/rtl/crc8dfr_pkg.sv
// Shared types and constants for the CRC-8 sync-word packet deframer.
// No dependencies; every other file of the block imports this package.

package crc8dfr_pkg;

   // Width of the good-frame and CRC-error counters.
   localparam int CRC8DFR_COUNT_WIDTH = 32;

   // CRC-8 generator polynomial (x^8 + x^2 + x + 1), MSB first, init 0.
   localparam logic [7:0] CRC_POLY = 8'h07;

   // Reset values of the two sync-byte registers.
   localparam logic [7:0] SYNC_FIRST_RESET  = 8'hAA;
   localparam logic [7:0] SYNC_SECOND_RESET = 8'h55;

   // Number of payload bytes covered by the CRC.
   localparam int PAYLOAD_BYTES = 4;

   // Byte position within a packet.
   typedef logic [2:0] byte_pos_type;

   localparam byte_pos_type POS_SYNC_FIRST  = 3'd0;
   localparam byte_pos_type POS_SYNC_SECOND = 3'd1;
   localparam byte_pos_type POS_POSITION_LO = 3'd2;
   localparam byte_pos_type POS_POSITION_HI = 3'd3;
   localparam byte_pos_type POS_CONFIDENCE  = 3'd4;
   localparam byte_pos_type POS_FRAME_ID    = 3'd5;
   localparam byte_pos_type POS_CRC         = 3'd6;

   // Configuration register indexes.
   typedef logic [1:0] csr_index_type;

   localparam csr_index_type CSR_SYNC_FIRST  = 2'd0;
   localparam csr_index_type CSR_SYNC_SECOND = 2'd1;

   // Per-byte status reported on the result channel.
   typedef enum logic [1:0] {
      STATUS_NONE      = 2'd0,
      STATUS_GOOD      = 2'd1,
      STATUS_CRC_ERROR = 2'd2
   } status_type;

endpackage

### hw/rtl/crc8dfr_if.sv
// Handshake channel interfaces of the CRC-8 packet deframer: received bytes,
// per-byte status words and configuration writes. Depends on crc8dfr_pkg.

// Received byte with its millisecond timestamp.
interface crc8dfr_req_if import crc8dfr_pkg::*; ();
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic [31:0] now_ms;

   modport source (output valid, output data_byte, output now_ms, input ready);
   modport sink   (input valid, input data_byte, input now_ms, output ready);
endinterface

// Status word with the latched sample and the frame counters.
interface crc8dfr_rsp_if import crc8dfr_pkg::*; #(
   parameter int COUNT_WIDTH = CRC8DFR_COUNT_WIDTH
) ();
   logic                    valid;
   logic                    ready;
   status_type              status;
   logic signed [15:0]      position;
   logic [7:0]              confidence;
   logic [7:0]              frame_id;
   logic [31:0]             timestamp_ms;
   logic                    sample_valid;
   logic [COUNT_WIDTH-1:0]  good_frames;
   logic [COUNT_WIDTH-1:0]  crc_errors;

   modport source (
      output valid, output status, output position, output confidence,
      output frame_id, output timestamp_ms, output sample_valid,
      output good_frames, output crc_errors, input ready
   );
   modport sink (
      input valid, input status, input position, input confidence,
      input frame_id, input timestamp_ms, input sample_valid,
      input good_frames, input crc_errors, output ready
   );
endinterface

// Configuration register write channel.
interface crc8dfr_csr_if import crc8dfr_pkg::*; ();
   logic          valid;
   logic          ready;
   csr_index_type index;
   logic [7:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/sync_crc8_packet_deframer.sv
// Top level of the CRC-8 sync-word packet deframer.
// Depends on crc8dfr_pkg, the interfaces in crc8dfr_if and crc8dfr_crc_step.
//
//   Channel  Direction  Word contents
//   req_ch   in         data_byte, now_ms
//   rsp_ch   out        status, position, confidence, frame_id, timestamp_ms,
//                       sample_valid, good_frames, crc_errors
//   csr_ch   in         index (0 sync_first, 1 sync_second), data
//
// One byte per cycle while status words are read: each accepted byte is processed in the cycle it is taken
// and its status word is valid from the next cycle on.
// The status word register frees up in the same cycle it is taken, so a new
// byte is accepted whenever the output slot is empty or being read.
// A stalled status word holds the deframer state; bytes wait until it is read.
// Synchronous reset clears all control state and the latched sample; neither
// channel accepts words while reset is high.

module sync_crc8_packet_deframer import crc8dfr_pkg::*; #(
   parameter int COUNT_WIDTH = CRC8DFR_COUNT_WIDTH
) (
   input  logic                clock,
   input  logic                reset,
   crc8dfr_req_if.sink         req_ch,
   crc8dfr_rsp_if.source       rsp_ch,
   crc8dfr_csr_if.sink         csr_ch
);

   // Configuration registers.
   logic [7:0] sync_first_ff;
   logic [7:0] sync_second_ff;

   // Deframer state.
   byte_pos_type             byte_pos_ff, byte_pos_in;
   logic [7:0]               crc_ff, crc_in;
   logic [7:0]               payload_ff [PAYLOAD_BYTES];
   logic signed [15:0]       last_position_ff;
   logic [7:0]               last_confidence_ff;
   logic [7:0]               last_frame_ff;
   logic [31:0]              last_time_ff;
   logic                     have_sample_ff;
   logic [COUNT_WIDTH-1:0]   good_count_ff;
   logic [COUNT_WIDTH-1:0]   error_count_ff;

   // Output slot.
   logic                     rsp_valid_ff;
   status_type               status_ff, status_in;

   logic       accept;
   logic       csr_write;
   logic       payload_write;
   logic [1:0] payload_idx;
   logic       frame_good;
   logic       frame_bad;
   logic [7:0] crc_next;

   // Handshakes: a byte enters when the status slot is free or being emptied.
   assign req_ch.ready = !reset && (!rsp_valid_ff || rsp_ch.ready);
   assign accept       = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = !reset;
   assign csr_write    = csr_ch.valid && csr_ch.ready;

   // Running CRC over the payload bytes.
   crc8dfr_crc_step u_crc_step (
      .crc       (crc_ff),
      .data_byte (req_ch.data_byte),
      .crc_next  (crc_next)
   );

   assign payload_idx = 2'(byte_pos_ff - POS_POSITION_LO);

   // Next-state logic of the packet parser for the current byte.
   always_comb begin
      byte_pos_in   = byte_pos_ff;
      crc_in        = crc_ff;
      status_in     = STATUS_NONE;
      payload_write = 1'b0;
      frame_good    = 1'b0;
      frame_bad     = 1'b0;
      unique case (byte_pos_ff)
         POS_SYNC_SECOND: begin
            if (req_ch.data_byte == sync_second_ff) begin
               byte_pos_in = POS_POSITION_LO;
            end else if (req_ch.data_byte == sync_first_ff) begin
               byte_pos_in = POS_SYNC_SECOND;
            end else begin
               byte_pos_in = POS_SYNC_FIRST;
            end
            crc_in = 8'h00;
         end
         POS_POSITION_LO, POS_POSITION_HI, POS_CONFIDENCE, POS_FRAME_ID: begin
            payload_write = 1'b1;
            crc_in        = crc_next;
            byte_pos_in   = byte_pos_ff + 3'd1;
         end
         POS_CRC: begin
            byte_pos_in = POS_SYNC_FIRST;
            crc_in      = 8'h00;
            if (crc_ff == req_ch.data_byte) begin
               frame_good = 1'b1;
               status_in  = STATUS_GOOD;
            end else begin
               frame_bad = 1'b1;
               status_in = STATUS_CRC_ERROR;
            end
         end
         // Searching for the first sync byte; the unused position falls here.
         default: begin
            if (req_ch.data_byte == sync_first_ff) begin
               byte_pos_in = POS_SYNC_SECOND;
               crc_in      = 8'h00;
            end else begin
               byte_pos_in = POS_SYNC_FIRST;
            end
         end
      endcase
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= SYNC_FIRST_RESET;
         sync_second_ff <= SYNC_SECOND_RESET;
      end else if (csr_write) begin
         if (csr_ch.index == CSR_SYNC_FIRST) begin
            sync_first_ff <= csr_ch.data;
         end
         if (csr_ch.index == CSR_SYNC_SECOND) begin
            sync_second_ff <= csr_ch.data;
         end
      end
   end

   // Parser state, latched sample, counters and the status slot.
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_pos_ff        <= POS_SYNC_FIRST;
         crc_ff             <= 8'h00;
         last_position_ff   <= 16'sd0;
         last_confidence_ff <= 8'h00;
         last_frame_ff      <= 8'h00;
         last_time_ff       <= 32'd0;
         have_sample_ff     <= 1'b0;
         good_count_ff      <= '0;
         error_count_ff     <= '0;
         rsp_valid_ff       <= 1'b0;
         status_ff          <= STATUS_NONE;
      end else begin
         if (accept) begin
            byte_pos_ff  <= byte_pos_in;
            crc_ff       <= crc_in;
            status_ff    <= status_in;
            rsp_valid_ff <= 1'b1;
            if (frame_good) begin
               last_position_ff   <= signed'({payload_ff[1], payload_ff[0]});
               last_confidence_ff <= payload_ff[2];
               last_frame_ff      <= payload_ff[3];
               last_time_ff       <= req_ch.now_ms;
               have_sample_ff     <= 1'b1;
               good_count_ff      <= good_count_ff + COUNT_WIDTH'(1);
            end
            if (frame_bad) begin
               error_count_ff <= error_count_ff + COUNT_WIDTH'(1);
            end
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload bytes of the packet in flight.
   always_ff @(posedge clock) begin
      if (accept && payload_write) begin
         payload_ff[payload_idx] <= req_ch.data_byte;
      end
   end

   // The state registers change only together with the status slot, so they
   // drive the result word directly.
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = status_ff;
   assign rsp_ch.position     = last_position_ff;
   assign rsp_ch.confidence   = last_confidence_ff;
   assign rsp_ch.frame_id     = last_frame_ff;
   assign rsp_ch.timestamp_ms = last_time_ff;
   assign rsp_ch.sample_valid = have_sample_ff;
   assign rsp_ch.good_frames  = good_count_ff;
   assign rsp_ch.crc_errors   = error_count_ff;

endmodule

### hw/rtl/crc8dfr_crc_step.sv
// One-byte update of the CRC-8 (polynomial 0x07, MSB first, no reflection).
// Depends on crc8dfr_pkg for the polynomial.

module crc8dfr_crc_step import crc8dfr_pkg::*; (
   input  logic [7:0] crc,
   input  logic [7:0] data_byte,
   output logic [7:0] crc_next
);

   // Eight shift-and-conditional-xor steps over the byte folded into the CRC.
   always_comb begin
      logic [7:0] c;
      c = crc ^ data_byte;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      crc_next = c;
   end

endmodule

### hw/rtl/crc8dfr_checker.sv
// Port-level checks for the CRC-8 packet deframer, bound to its top level.
// Depends on crc8dfr_pkg and on the ports of sync_crc8_packet_deframer.

module crc8dfr_checker import crc8dfr_pkg::*; #(
   parameter int COUNT_WIDTH = CRC8DFR_COUNT_WIDTH
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input status_type             rsp_status,
   input logic                   rsp_sample_valid,
   input logic [COUNT_WIDTH-1:0] rsp_good_frames,
   input logic [COUNT_WIDTH-1:0] rsp_crc_errors
);

   // A stalled status word holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("status word changed while stalled");

   // No status word is pending right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("status word valid after reset");

   // A good frame always leaves a valid sample behind.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_GOOD |-> rsp_sample_valid)
      else $error("good frame reported without a latched sample");

   // Counters move only when a byte is taken.
   assert property (@(posedge clock) disable iff (reset)
      !(req_valid && req_ready) |=> $stable(rsp_good_frames) && $stable(rsp_crc_errors))
      else $error("frame counter changed without an accepted byte");

   // While the consumer takes words, bytes stream in every cycle.
   assert property (@(posedge clock) disable iff (reset) rsp_ready |-> req_ready)
      else $error("input stalled although the output is being read");

endmodule

bind sync_crc8_packet_deframer crc8dfr_checker #(
   .COUNT_WIDTH (COUNT_WIDTH)
) u_crc8dfr_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_status       (rsp_ch.status),
   .rsp_sample_valid (rsp_ch.sample_valid),
   .rsp_good_frames  (rsp_ch.good_frames),
   .rsp_crc_errors   (rsp_ch.crc_errors)
);

### tb/sync_crc8_packet_deframer_test.sv
// Self-checking testbench for the CRC-8 sync-word packet deframer.
// Depends on crc8dfr_pkg, the channel interfaces in crc8dfr_if and the deframer RTL.

module sync_crc8_packet_deframer_test;
   timeunit 1ns;
   timeprecision 1ps;
   import crc8dfr_pkg::*;

   localparam int IDLE_PERCENT = 22;
   localparam int STALL_LIMIT  = 1000;
   localparam int PHASE_BYTES  = 305;
   localparam int PHASE_COUNT  = 6;

   // One status word as it leaves the deframer.
   typedef struct packed {
      status_type                      status;
      logic signed [15:0]              position;
      logic [7:0]                      confidence;
      logic [7:0]                      frame_id;
      logic [31:0]                     timestamp_ms;
      logic                            sample_valid;
      logic [CRC8DFR_COUNT_WIDTH-1:0]  good_frames;
      logic [CRC8DFR_COUNT_WIDTH-1:0]  crc_errors;
   } status_word_type;

   // One row of the directed byte stream; typed rows carry a known status.
   typedef struct packed {
      logic [7:0]  data_byte;
      logic [31:0] now_ms;
      logic        typed;
      status_type  status;
   } stim_row_type;

   logic clock;
   logic reset;

   crc8dfr_req_if req_ch ();
   crc8dfr_rsp_if #(.COUNT_WIDTH(CRC8DFR_COUNT_WIDTH)) rsp_ch ();
   crc8dfr_csr_if csr_ch ();

   sync_crc8_packet_deframer #(.COUNT_WIDTH(CRC8DFR_COUNT_WIDTH)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Typed status travels alongside the byte so the checker sees it on acceptance.
   logic       req_typed;
   status_type req_typed_status;

   // Predicted deframer state and configuration.
   logic [7:0]                     cfg_sync_first;
   logic [7:0]                     cfg_sync_second;
   byte_pos_type                   frame_pos;
   logic [7:0]                     crc_acc;
   logic [7:0]                     payload_buf [PAYLOAD_BYTES];
   logic [15:0]                    held_position;
   logic [7:0]                     held_confidence;
   logic [7:0]                     held_frame_id;
   logic [31:0]                    held_time;
   logic                           held_valid;
   logic [CRC8DFR_COUNT_WIDTH-1:0] good_total;
   logic [CRC8DFR_COUNT_WIDTH-1:0] error_total;

   status_word_type pending_words [$];

   int  bytes_sent;
   int  words_checked;
   int  reg_writes;
   int  frames_good;
   int  frames_dropped;
   int  failures;
   int  stall_cycles;
   bit  no_idle;

   stim_row_type directed_rows [26] = '{
      // After reset, with no sync seen yet.
      '{8'h00, 32'h0000_0000, 1'b1, STATUS_NONE},
      '{8'hFF, 32'hFFFF_FFFF, 1'b1, STATUS_NONE},
      // First sync byte followed by a wrong second byte drops back to search.
      '{8'hAA, 32'h0000_0001, 1'b1, STATUS_NONE},
      '{8'h00, 32'h0000_0002, 1'b1, STATUS_NONE},
      // All-zero payload has a zero CRC, so this frame is good.
      '{8'hAA, 32'h0000_0003, 1'b1, STATUS_NONE},
      '{8'h55, 32'h0000_0004, 1'b1, STATUS_NONE},
      '{8'h00, 32'h0000_0005, 1'b1, STATUS_NONE},
      '{8'h00, 32'h0000_0006, 1'b1, STATUS_NONE},
      '{8'h00, 32'h0000_0007, 1'b1, STATUS_NONE},
      '{8'h00, 32'h0000_0008, 1'b1, STATUS_NONE},
      '{8'h00, 32'hFFFF_FFFF, 1'b1, STATUS_GOOD},
      // A repeated first sync byte restarts the frame; all-ones payload.
      '{8'hAA, 32'h0000_0009, 1'b1, STATUS_NONE},
      '{8'hAA, 32'h0000_000A, 1'b1, STATUS_NONE},
      '{8'h55, 32'h0000_000B, 1'b1, STATUS_NONE},
      '{8'hFF, 32'h0000_000C, 1'b1, STATUS_NONE},
      '{8'hFF, 32'h0000_000D, 1'b1, STATUS_NONE},
      '{8'hFF, 32'h0000_000E, 1'b1, STATUS_NONE},
      '{8'hFF, 32'h0000_000F, 1'b1, STATUS_NONE},
      '{8'hDE, 32'h8000_0000, 1'b0, STATUS_NONE},
      // Zero payload with a nonzero CRC byte is dropped.
      '{8'hAA, 32'h0000_0010, 1'b1, STATUS_NONE},
      '{8'h55, 32'h0000_0011, 1'b1, STATUS_NONE},
      '{8'h00, 32'h0000_0012, 1'b1, STATUS_NONE},
      '{8'h00, 32'h0000_0013, 1'b1, STATUS_NONE},
      '{8'h00, 32'h0000_0014, 1'b1, STATUS_NONE},
      '{8'h00, 32'h0000_0015, 1'b1, STATUS_NONE},
      '{8'h01, 32'h7FFF_FFFF, 1'b1, STATUS_CRC_ERROR}
   };

   // Clock generation.
   always #4 clock = ~clock;

   // One MSB-first CRC-8 step over a byte, initial value zero.
   function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++)
         c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      return c;
   endfunction

   function automatic void deframer_reset();
      cfg_sync_first  = SYNC_FIRST_RESET;
      cfg_sync_second = SYNC_SECOND_RESET;
      frame_pos       = POS_SYNC_FIRST;
      crc_acc         = '0;
      foreach (payload_buf[i])
         payload_buf[i] = '0;
      held_position   = '0;
      held_confidence = '0;
      held_frame_id   = '0;
      held_time       = '0;
      held_valid      = 1'b0;
      good_total      = '0;
      error_total     = '0;
   endfunction

   // Advances the predicted deframer by one byte and returns its status word.
   function automatic status_word_type deframe_byte(input logic [7:0] b,
                                                    input logic [31:0] now);
      status_word_type w;
      w.status = STATUS_NONE;
      // The unused position value behaves as the search state.
      if (frame_pos > POS_CRC)
         frame_pos = POS_SYNC_FIRST;
      case (frame_pos)
         POS_SYNC_FIRST: begin
            if (b == cfg_sync_first) begin
               frame_pos = POS_SYNC_SECOND;
               crc_acc   = '0;
            end
         end
         POS_SYNC_SECOND: begin
            // Second sync is tested first, so equal sync values advance.
            if (b == cfg_sync_second)
               frame_pos = POS_POSITION_LO;
            else if (b == cfg_sync_first)
               frame_pos = POS_SYNC_SECOND;
            else
               frame_pos = POS_SYNC_FIRST;
            crc_acc = '0;
         end
         POS_CRC: begin
            frame_pos = POS_SYNC_FIRST;
            if (crc_acc == b) begin
               held_position   = {payload_buf[1], payload_buf[0]};
               held_confidence = payload_buf[2];
               held_frame_id   = payload_buf[3];
               held_time       = now;
               held_valid      = 1'b1;
               good_total      = good_total + 1'b1;
               w.status        = STATUS_GOOD;
            end else begin
               error_total = error_total + 1'b1;
               w.status    = STATUS_CRC_ERROR;
            end
            crc_acc = '0;
         end
         default: begin
            payload_buf[2'(frame_pos - POS_POSITION_LO)] = b;
            crc_acc   = crc8_next(crc_acc, b);
            frame_pos = byte_pos_type'(frame_pos + 3'd1);
         end
      endcase
      w.position     = held_position;
      w.confidence   = held_confidence;
      w.frame_id     = held_frame_id;
      w.timestamp_ms = held_time;
      w.sample_valid = held_valid;
      w.good_frames  = good_total;
      w.crc_errors   = error_total;
      return w;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got_val,
                                  input logic [31:0] exp_val);
      failures++;
      $display("MISMATCH word %0d %s: got %0h, expected %0h",
               words_checked, what, got_val, exp_val);
   endtask

   task automatic compare_word(input status_word_type got, input status_word_type exp);
      if (got.status !== exp.status)
         report_mismatch("status", got.status, exp.status);
      if (got.position !== exp.position)
         report_mismatch("position", got.position, exp.position);
      if (got.confidence !== exp.confidence)
         report_mismatch("confidence", got.confidence, exp.confidence);
      if (got.frame_id !== exp.frame_id)
         report_mismatch("frame_id", got.frame_id, exp.frame_id);
      if (got.timestamp_ms !== exp.timestamp_ms)
         report_mismatch("timestamp_ms", got.timestamp_ms, exp.timestamp_ms);
      if (got.sample_valid !== exp.sample_valid)
         report_mismatch("sample_valid", got.sample_valid, exp.sample_valid);
      if (got.good_frames !== exp.good_frames)
         report_mismatch("good_frames", got.good_frames, exp.good_frames);
      if (got.crc_errors !== exp.crc_errors)
         report_mismatch("crc_errors", got.crc_errors, exp.crc_errors);
   endtask

   // Status words are stalled at random, except during the steady stretch.
   always @(posedge clock) begin
      rsp_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
   end

   // Checker, predictor feed and watchdog, all sampled at the clock edge.
   always @(posedge clock) begin
      status_word_type got;
      status_word_type predicted;
      logic progress;
      if (!reset) begin
         progress = 1'b0;
         // Status word leaving the block: compare with the oldest prediction.
         if (rsp_ch.valid && rsp_ch.ready) begin
            progress           = 1'b1;
            got.status         = rsp_ch.status;
            got.position       = rsp_ch.position;
            got.confidence     = rsp_ch.confidence;
            got.frame_id       = rsp_ch.frame_id;
            got.timestamp_ms   = rsp_ch.timestamp_ms;
            got.sample_valid   = rsp_ch.sample_valid;
            got.good_frames    = rsp_ch.good_frames;
            got.crc_errors     = rsp_ch.crc_errors;
            if (pending_words.size() == 0)
               report_mismatch("unexpected word, status", got.status, '0);
            else
               compare_word(got, pending_words.pop_front());
            if (got.status == STATUS_GOOD)
               frames_good++;
            if (got.status == STATUS_CRC_ERROR)
               frames_dropped++;
            words_checked++;
         end
         // Register write taken by the block.
         if (csr_ch.valid && csr_ch.ready) begin
            progress = 1'b1;
            case (csr_ch.index)
               CSR_SYNC_FIRST:  cfg_sync_first  = csr_ch.data;
               CSR_SYNC_SECOND: cfg_sync_second = csr_ch.data;
               default: ;
            endcase
            reg_writes++;
         end
         // Byte taken by the block: predict its status word.
         if (req_ch.valid && req_ch.ready) begin
            progress  = 1'b1;
            predicted = deframe_byte(req_ch.data_byte, req_ch.now_ms);
            if (req_typed)
               predicted.status = req_typed_status;
            pending_words.push_back(predicted);
         end
         stall_cycles = progress ? 0 : stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Watchdog expired after %0d cycles without a handshake", STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // Payload byte with a bias toward the sign and range extremes.
   function automatic logic [7:0] rand_byte();
      case ($urandom_range(7))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return 8'h7F;
         3:       return 8'h80;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Offers one byte and waits until the block takes it.
   task automatic send_byte(input logic [7:0] data, input logic [31:0] now,
                            input logic typed, input status_type status);
      while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.data_byte <= data;
      req_ch.now_ms    <= now;
      req_typed        <= typed;
      req_typed_status <= status;
      do
         @(posedge clock);
      while (!req_ch.ready);
      bytes_sent++;
   endtask

   // Mostly well-formed frames with random content, some noise and broken frames.
   task automatic send_random_frame();
      int         pick;
      logic [7:0] body;
      logic [7:0] crc;
      pick = $urandom_range(99);
      if (pick < 10) begin
         repeat ($urandom_range(1, 4))
            send_byte(($urandom_range(3) == 0) ? cfg_sync_first : 8'($urandom_range(255)),
                      $urandom, 1'b0, STATUS_NONE);
      end else if (pick < 20) begin
         send_byte(cfg_sync_first, $urandom, 1'b0, STATUS_NONE);
         if ($urandom_range(1) == 0) begin
            // Bad second sync byte, sometimes a repeated first one.
            send_byte(($urandom_range(1) == 0) ? cfg_sync_first : 8'($urandom_range(255)),
                      $urandom, 1'b0, STATUS_NONE);
         end else begin
            // Frame cut short; following bytes land in its payload.
            send_byte(cfg_sync_second, $urandom, 1'b0, STATUS_NONE);
            repeat ($urandom_range(0, 3))
               send_byte(rand_byte(), $urandom, 1'b0, STATUS_NONE);
         end
      end else begin
         crc = '0;
         send_byte(cfg_sync_first, $urandom, 1'b0, STATUS_NONE);
         send_byte(cfg_sync_second, $urandom, 1'b0, STATUS_NONE);
         repeat (PAYLOAD_BYTES) begin
            body = rand_byte();
            crc  = crc8_next(crc, body);
            send_byte(body, $urandom, 1'b0, STATUS_NONE);
         end
         if ($urandom_range(99) < 20)
            crc = crc ^ 8'($urandom_range(1, 255));
         send_byte(crc, $urandom, 1'b0, STATUS_NONE);
      end
   endtask

   // Stops offering bytes and waits until every predicted word has come back.
   task automatic drain_stream();
      req_ch.valid <= 1'b0;
      wait (words_checked == bytes_sent);
      @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [7:0] val);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      do
         @(posedge clock);
      while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Main sequence: reset, directed rows, then random phases under several sync settings.
   initial begin
      int         phase_start;
      logic [7:0] first_val;
      logic [7:0] second_val;
      clock            = 1'b0;
      reset            = 1'b1;
      no_idle          = 1'b0;
      req_ch.valid     = 1'b0;
      req_ch.data_byte = '0;
      req_ch.now_ms    = '0;
      req_typed        = 1'b0;
      req_typed_status = STATUS_NONE;
      rsp_ch.ready     = 1'b0;
      csr_ch.valid     = 1'b0;
      csr_ch.index     = CSR_SYNC_FIRST;
      csr_ch.data      = '0;
      bytes_sent       = 0;
      words_checked    = 0;
      reg_writes       = 0;
      frames_good      = 0;
      frames_dropped   = 0;
      failures         = 0;
      stall_cycles     = 0;
      deframer_reset();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_byte(directed_rows[i].data_byte, directed_rows[i].now_ms,
                   directed_rows[i].typed, directed_rows[i].status);

      for (int p = 0; p < PHASE_COUNT; p++) begin
         if (p > 0) begin
            case (p)
               1:       begin first_val = 8'h00; second_val = 8'hFF; end
               2:       begin first_val = 8'hFF; second_val = 8'h00; end
               3:       begin first_val = 8'h3C; second_val = 8'h3C; end
               4:       begin
                  first_val  = 8'($urandom_range(255));
                  second_val = 8'($urandom_range(255));
               end
               default: begin first_val = SYNC_FIRST_RESET; second_val = SYNC_SECOND_RESET; end
            endcase
            drain_stream();
            write_reg(CSR_SYNC_FIRST, first_val);
            write_reg(CSR_SYNC_SECOND, second_val);
         end
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PHASE_BYTES) begin
            // The first half of the opening phase runs with no idling on either side.
            no_idle = (p == 0) && (bytes_sent - phase_start < PHASE_BYTES / 2);
            send_random_frame();
         end
         no_idle = 1'b0;
      end

      drain_stream();
      repeat (4) @(posedge clock);
      if (pending_words.size() != 0)
         report_mismatch("words never delivered", pending_words.size(), '0);

      $display("Run covered %0d bytes in %0d sync settings with %0d register writes.",
               bytes_sent, PHASE_COUNT, reg_writes);
      $display("Frames finished: %0d good, %0d dropped for CRC error.",
               frames_good, frames_dropped);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
